// ----- rtl/rrqs_pkg.sv -----
// Shared types and constants of the time-slice job scheduler.
// Used by rrqs_ctrl, rrqs_dp and round_robin_quantum_scheduler; depends on nothing.
`default_nettype none
package rrqs_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int JOB_UNITS   = 3;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int REM_W       = 2;
	localparam int CMP_W       = 5;

	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 120;

	// Request codes carried on the input tuser.
	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	// Result kinds carried on the output tuser.
	localparam logic [2:0] KIND_SLICE = 3'd0;
	localparam logic [2:0] KIND_ENTRY = 3'd1;
	localparam logic [2:0] KIND_ADD   = 3'd2;
	localparam logic [2:0] KIND_REM   = 3'd3;
	localparam logic [2:0] KIND_NONE  = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_QUANTUM  = 1'b0;
	localparam logic CFG_OVERHEAD = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [15:0] job_owner;
		logic [31:0] time_value;
		logic [31:0] first_start;
		logic        started;
		logic [31:0] finish_time;
		logic        finished;
		logic [1:0]  status;
		logic        last;
	} res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic add_exec;
		logic read_exec;
		logic rem_step;
		logic rem_finish;
		logic slice_exec;
		logic adv_run;
		logic none_emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
		logic any_pend;
		logic cur_pend;
		logic last_slice;
		logic rem_done;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/rrqs_dp.sv -----
// Datapath of the scheduler: job table, clock, scan counters, config and result register.
// Depends on rrqs_pkg; driven by commands from rrqs_ctrl.
`default_nettype none
module rrqs_dp
	import rrqs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_addr,
	input  wire logic [7:0]           cfg_wdata,
	input  wire logic [1:0]           in_req,
	input  wire logic [15:0]          in_owner,
	input  wire logic [3:0]           in_index,
	input  wire cmd_t                 cmd,
	output stat_t                     stat,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output res_t                      out_res
);

	// Job table: one write address per cycle; the pending flags read the remaining count of every entry.
	logic [15:0]      owner_q [MAX_ENTRIES];
	logic [REM_W-1:0] rem_q   [MAX_ENTRIES];
	logic [31:0]      arr_q   [MAX_ENTRIES];
	logic [31:0]      start_q [MAX_ENTRIES];
	logic             sv_q    [MAX_ENTRIES];
	logic [31:0]      fin_q   [MAX_ENTRIES];
	logic             fv_q    [MAX_ENTRIES];

	logic [CNT_W-1:0] count_q;
	logic [31:0]      clock_q;
	logic [7:0]       quantum_q;
	logic [7:0]       overhead_q;
	logic [CNT_W-1:0] ptr_q;
	logic [CNT_W-1:0] keep_q;
	logic [1:0]       req_q;
	logic [15:0]      owner_req_q;
	logic [3:0]       index_req_q;
	logic             out_valid_q;
	res_t             res_q;

	logic [IDX_W-1:0]      rd_idx;
	logic [IDX_W-1:0]      ptr_idx;
	logic [IDX_W-1:0]      keep_idx;
	logic [IDX_W-1:0]      cnt_idx;
	logic [MAX_ENTRIES-1:0] pend;
	logic [MAX_ENTRIES-1:0] pend_after;
	logic [7:0]            q_eff;
	logic [REM_W-1:0]      play;
	logic [REM_W-1:0]      rem_next;
	logic [9:0]            step_units;
	logic [32:0]           clock_sum;
	logic [31:0]           clock_next;
	logic [CNT_W-1:0]      ptr_inc;
	logic [CNT_W-1:0]      ptr_wrap;
	logic                  full;
	logic                  read_ok;
	logic                  emit;
	logic                  out_free;
	res_t                  res_d;

	assign ptr_idx  = ptr_q[IDX_W-1:0];
	assign keep_idx = keep_q[IDX_W-1:0];
	assign cnt_idx  = count_q[IDX_W-1:0];
	assign rd_idx   = (req_q == REQ_READ) ? index_req_q[IDX_W-1:0] : ptr_idx;
	assign full     = (count_q == CNT_W'(MAX_ENTRIES));
	assign read_ok  = ({1'b0, index_req_q} < CMP_W'(count_q));

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			pend[i] = (CNT_W'(i) < count_q) && (rem_q[i] != '0);
		end
	end

	// One slice: min(remaining, quantum), then the overhead, saturating.
	assign q_eff      = (quantum_q == 8'd0) ? 8'd1 : quantum_q;
	assign play       = ({6'd0, rem_q[ptr_idx]} < q_eff) ? rem_q[ptr_idx] : q_eff[REM_W-1:0];
	assign rem_next   = rem_q[ptr_idx] - play;
	assign step_units = 10'(play) + 10'(overhead_q);
	assign clock_sum  = {1'b0, clock_q} + 33'(step_units);
	assign clock_next = clock_sum[32] ? 32'hFFFF_FFFF : clock_sum[31:0];

	always_comb begin
		pend_after          = pend;
		pend_after[ptr_idx] = (rem_next != '0);
	end

	assign ptr_inc  = CNT_W'(ptr_q + 1'b1);
	assign ptr_wrap = (ptr_inc == count_q) ? '0 : ptr_inc;

	assign out_free = !out_valid_q || out_ready;
	assign emit     = cmd.add_exec || cmd.read_exec || cmd.rem_finish || cmd.slice_exec ||
		cmd.none_emit;

	assign stat.out_free   = out_free;
	assign stat.any_pend   = (pend != '0);
	assign stat.cur_pend   = pend[ptr_idx];
	assign stat.last_slice = (pend_after == '0);
	assign stat.rem_done   = (ptr_q == count_q);

	always_comb begin
		res_d = '0;
		if (cmd.add_exec) begin
			res_d.kind      = KIND_ADD;
			res_d.job_owner = owner_req_q;
			res_d.last      = 1'b1;
			if (full) begin
				res_d.status = STAT_FULL;
			end else begin
				res_d.slot       = 4'(cnt_idx);
				res_d.time_value = clock_q;
			end
		end else if (cmd.read_exec) begin
			res_d.kind = KIND_ENTRY;
			res_d.last = 1'b1;
			if (read_ok) begin
				res_d.slot        = index_req_q;
				res_d.job_owner   = owner_q[rd_idx];
				res_d.time_value  = arr_q[rd_idx];
				res_d.started     = sv_q[rd_idx];
				res_d.first_start = sv_q[rd_idx] ? start_q[rd_idx] : 32'd0;
				res_d.finished    = fv_q[rd_idx];
				res_d.finish_time = fv_q[rd_idx] ? fin_q[rd_idx] : 32'd0;
			end else begin
				res_d.slot   = index_req_q;
				res_d.status = STAT_EMPTY;
			end
		end else if (cmd.slice_exec) begin
			res_d.kind        = KIND_SLICE;
			res_d.slot        = 4'(ptr_idx);
			res_d.job_owner   = owner_q[rd_idx];
			res_d.time_value  = clock_q;
			res_d.started     = 1'b1;
			res_d.first_start = sv_q[rd_idx] ? start_q[rd_idx] : clock_q;
			res_d.finished    = (rem_next == '0);
			res_d.finish_time = (rem_next == '0) ? clock_next : 32'd0;
			res_d.last        = (pend_after == '0);
		end else if (cmd.rem_finish) begin
			res_d.kind = KIND_REM;
			res_d.last = 1'b1;
		end else if (cmd.none_emit) begin
			res_d.kind = KIND_NONE;
			res_d.last = 1'b1;
		end
	end

	// Table writes; the table has no reset.
	always_ff @(posedge clk) begin
		if (cmd.add_exec && !full) begin
			owner_q[cnt_idx] <= owner_req_q;
			rem_q[cnt_idx]   <= REM_W'(JOB_UNITS);
			arr_q[cnt_idx]   <= clock_q;
			sv_q[cnt_idx]    <= 1'b0;
			fv_q[cnt_idx]    <= 1'b0;
		end else if (cmd.rem_step && (owner_q[rd_idx] != owner_req_q)) begin
			// Kept jobs move down in order and start over from arrival zero.
			owner_q[keep_idx] <= owner_q[rd_idx];
			rem_q[keep_idx]   <= REM_W'(JOB_UNITS);
			arr_q[keep_idx]   <= 32'd0;
			sv_q[keep_idx]    <= 1'b0;
			fv_q[keep_idx]    <= 1'b0;
		end else if (cmd.slice_exec) begin
			rem_q[ptr_idx] <= rem_next;
			if (!sv_q[ptr_idx]) begin
				start_q[ptr_idx] <= clock_q;
				sv_q[ptr_idx]    <= 1'b1;
			end
			if (rem_next == '0) begin
				fin_q[ptr_idx] <= clock_next;
				fv_q[ptr_idx]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q       <= in_req;
			owner_req_q <= in_owner;
			index_req_q <= in_index;
		end
		if (emit && out_free) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			clock_q     <= '0;
			quantum_q   <= 8'd1;
			overhead_q  <= 8'd0;
			ptr_q       <= '0;
			keep_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_QUANTUM:  quantum_q  <= cfg_wdata;
					CFG_OVERHEAD: overhead_q <= cfg_wdata;
					default:      ;
				endcase
			end
			if (cmd.load_req) begin
				ptr_q  <= '0;
				keep_q <= '0;
			end
			if (cmd.add_exec && !full) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
			if (cmd.rem_step) begin
				ptr_q <= ptr_inc;
				if (owner_q[rd_idx] != owner_req_q) begin
					keep_q <= CNT_W'(keep_q + 1'b1);
				end
			end
			if (cmd.rem_finish) begin
				count_q <= keep_q;
				clock_q <= '0;
			end
			if (cmd.slice_exec) begin
				clock_q <= clock_next;
				ptr_q   <= ptr_wrap;
			end
			if (cmd.adv_run) begin
				ptr_q <= ptr_wrap;
			end
			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

// ----- rtl/rrqs_ctrl.sv -----
// Controller state machine of the scheduler: sequences add, remove, run and read.
// Depends on rrqs_pkg; talks to rrqs_dp through cmd_t and stat_t.
`default_nettype none
module rrqs_ctrl
	import rrqs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_req,
	output logic            in_ready,
	input  wire stat_t      stat,
	output cmd_t            cmd
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_ADD      = 3'd1;
	localparam logic [2:0] ST_READ     = 3'd2;
	localparam logic [2:0] ST_REM      = 3'd3;
	localparam logic [2:0] ST_REM_DONE = 3'd4;
	localparam logic [2:0] ST_RUN      = 3'd5;
	localparam logic [2:0] ST_NONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					unique case (in_req)
						REQ_ADD:    state_d = ST_ADD;
						REQ_REMOVE: state_d = ST_REM;
						REQ_RUN:    state_d = stat.any_pend ? ST_RUN : ST_NONE;
						REQ_READ:   state_d = ST_READ;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (stat.out_free) begin
					cmd.add_exec = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_READ: begin
				if (stat.out_free) begin
					cmd.read_exec = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_REM: begin
				if (stat.rem_done) begin
					state_d = ST_REM_DONE;
				end else begin
					cmd.rem_step = 1'b1;
				end
			end
			ST_REM_DONE: begin
				if (stat.out_free) begin
					cmd.rem_finish = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_RUN: begin
				// Finished slots are stepped over one per cycle.
				if (!stat.cur_pend) begin
					cmd.adv_run = 1'b1;
				end else if (stat.out_free) begin
					cmd.slice_exec = 1'b1;
					if (stat.last_slice) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NONE: begin
				if (stat.out_free) begin
					cmd.none_emit = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/round_robin_quantum_scheduler.sv -----
// Top level of the time-slice job scheduler: controller plus datapath, stream ports.
// Depends on rrqs_pkg, rrqs_ctrl and rrqs_dp.
`default_nettype none
// The block keeps a table of up to 16 jobs and handles one request at a time; the input
// is ready only while no request is in progress. Add and read give their result once
// the output register is free; remove steps through every table entry, moving the kept
// jobs down, and then gives its result; run steps through the slots, giving a slice for
// each pending job on every pass and stepping over finished slots until none is pending,
// and a run with nothing pending gives a single none result. A result waits in the output
// register, and while one is held with m_tready low, a request that has a result to give
// stalls. Register writes are taken at any time.
module round_robin_quantum_scheduler
	import rrqs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_addr,
	input  wire logic [7:0]            cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// owner_id [15:0], entry_index [19:16], zero [23:20]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// req_type [1:0]
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// slot [3:0], job_owner [19:4], time_value [51:20], first_start [83:52], started [84],
	// finish_time [116:85], finished [117], status [119:118]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// kind [2:0]
	output logic [2:0]                 m_tuser,
	output logic                       m_tlast
);

	cmd_t  cmd;
	stat_t stat;
	res_t  res;

	rrqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_req   (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrqs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_req    (s_tuser),
		.in_owner  (s_tdata[15:0]),
		.in_index  (s_tdata[19:16]),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = {res.status, res.finished, res.finish_time, res.started,
		res.first_start, res.time_value, res.job_owner, res.slot};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule
`default_nettype wire

// ----- tb/sv/sched_checker.sv -----
// Checker for the time-slice job scheduler: watches the request, result and register ports.
// Keeps its own job table and clock, predicts the result words and compares them in order.
// Depends on rrqs_pkg for the request codes, result kinds and the result word layout.
module sched_checker
	import rrqs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_addr,
	input  wire logic [7:0]            cfg_wdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	// owner_id [15:0], entry_index [19:16], zero [23:20]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// req_type [1:0]
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	// slot [3:0], job_owner [19:4], time_value [51:20], first_start [83:52], started [84],
	// finish_time [116:85], finished [117], status [119:118]
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	// kind [2:0]
	input  wire logic [2:0]            m_tuser,
	input  wire logic                  m_tlast,
	output int unsigned                err_count,
	output int unsigned                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_CAP = 100;

	logic [15:0] job_owner_q [MAX_ENTRIES];
	logic [1:0]  job_left    [MAX_ENTRIES];
	logic [31:0] job_arrive  [MAX_ENTRIES];
	logic [31:0] job_first   [MAX_ENTRIES];
	logic        job_ran     [MAX_ENTRIES];
	logic [31:0] job_done_at [MAX_ENTRIES];
	logic        job_fin     [MAX_ENTRIES];
	int          job_count;
	logic [31:0] sched_now;
	logic [7:0]  quantum_reg;
	logic [7:0]  overhead_reg;

	res_t        expected_words [$];
	int unsigned word_no;

	task automatic report(input string msg);
		if (err_count < PRINT_CAP)
			$display("[%0t] %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report($sformatf("word %0d field %s: got %0h, expected %0h",
				word_no, name, got, want));
	endtask

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic res_t job_word(input logic [2:0] kind, input int i,
		input logic [31:0] tval);
		res_t w;
		w             = '0;
		w.kind        = kind;
		w.slot        = i[3:0];
		w.job_owner   = job_owner_q[i];
		w.time_value  = tval;
		w.first_start = job_ran[i] ? job_first[i] : 32'd0;
		w.started     = job_ran[i];
		w.finish_time = job_fin[i] ? job_done_at[i] : 32'd0;
		w.finished    = job_fin[i];
		return w;
	endfunction

	task automatic append_job(input logic [15:0] owner);
		job_owner_q[job_count] = owner;
		job_left[job_count]    = 2'(JOB_UNITS);
		job_arrive[job_count]  = sched_now;
		job_first[job_count]   = '0;
		job_ran[job_count]     = 1'b0;
		job_done_at[job_count] = '0;
		job_fin[job_count]     = 1'b0;
		job_count++;
	endtask

	task automatic clear_table();
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			job_owner_q[i] = '0;
			job_left[i]    = '0;
			job_arrive[i]  = '0;
			job_first[i]   = '0;
			job_ran[i]     = 1'b0;
			job_done_at[i] = '0;
			job_fin[i]     = 1'b0;
		end
		job_count    = 0;
		sched_now    = '0;
		quantum_reg  = 8'd1;
		overhead_reg = 8'd0;
	endtask

	task automatic predict_request(input logic [1:0] req, input logic [15:0] owner,
		input logic [3:0] idx);
		res_t        w;
		res_t        held;
		bit          have;
		bit          busy;
		logic [15:0] keep [MAX_ENTRIES];
		int          k;
		logic [7:0]  q;
		logic [7:0]  play;
		logic [31:0] t0;
		w    = '0;
		held = '0;
		have = 0;
		k    = 0;
		case (req)
			REQ_ADD: begin
				w.kind      = KIND_ADD;
				w.job_owner = owner;
				if (job_count >= MAX_ENTRIES) begin
					w.status = STAT_FULL;
				end else begin
					w.slot       = job_count[3:0];
					w.time_value = sched_now;
					append_job(owner);
				end
				w.last = 1'b1;
				expected_words.push_back(w);
			end
			REQ_REMOVE: begin
				for (int i = 0; i < job_count; i++)
					if (job_owner_q[i] != owner) begin
						keep[k] = job_owner_q[i];
						k++;
					end
				job_count = 0;
				sched_now = '0;
				for (int i = 0; i < k; i++)
					append_job(keep[i]);
				w.kind = KIND_REM;
				w.last = 1'b1;
				expected_words.push_back(w);
			end
			REQ_RUN: begin
				q = (quantum_reg == 8'd0) ? 8'd1 : quantum_reg;
				do begin
					busy = 0;
					for (int i = 0; i < job_count; i++) begin
						if (job_left[i] != 2'd0) begin
							t0 = sched_now;
							if (!job_ran[i]) begin
								job_first[i] = t0;
								job_ran[i]   = 1'b1;
							end
							play = ({6'd0, job_left[i]} < q) ? {6'd0, job_left[i]} : q;
							job_left[i] = job_left[i] - play[1:0];
							sched_now   = sat_add(sched_now, {24'd0, play});
							sched_now   = sat_add(sched_now, {24'd0, overhead_reg});
							if (job_left[i] == 2'd0) begin
								job_done_at[i] = sched_now;
								job_fin[i]     = 1'b1;
							end else begin
								busy = 1;
							end
							// The previous word is known not to be the last one now.
							if (have)
								expected_words.push_back(held);
							held = job_word(KIND_SLICE, i, t0);
							have = 1;
						end
					end
				end while (busy);
				if (!have)
					held.kind = KIND_NONE;
				held.last = 1'b1;
				expected_words.push_back(held);
			end
			default: begin
				if (int'(idx) < job_count) begin
					w = job_word(KIND_ENTRY, int'(idx), job_arrive[idx]);
				end else begin
					w.kind   = KIND_ENTRY;
					w.slot   = idx;
					w.status = STAT_EMPTY;
				end
				w.last = 1'b1;
				expected_words.push_back(w);
			end
		endcase
	endtask

	task automatic check_word();
		res_t got;
		res_t want;
		got.kind        = m_tuser;
		got.slot        = m_tdata[3:0];
		got.job_owner   = m_tdata[19:4];
		got.time_value  = m_tdata[51:20];
		got.first_start = m_tdata[83:52];
		got.started     = m_tdata[84];
		got.finish_time = m_tdata[116:85];
		got.finished    = m_tdata[117];
		got.status      = m_tdata[119:118];
		got.last        = m_tlast;
		if (expected_words.size() == 0) begin
			report($sformatf("word %0d arrived with nothing expected", word_no));
		end else begin
			want = expected_words.pop_front();
			check_field("kind", 32'(got.kind), 32'(want.kind));
			check_field("slot", 32'(got.slot), 32'(want.slot));
			check_field("job_owner", 32'(got.job_owner), 32'(want.job_owner));
			check_field("time_value", got.time_value, want.time_value);
			check_field("first_start", got.first_start, want.first_start);
			check_field("started", 32'(got.started), 32'(want.started));
			check_field("finish_time", got.finish_time, want.finish_time);
			check_field("finished", 32'(got.finished), 32'(want.finished));
			check_field("status", 32'(got.status), 32'(want.status));
			check_field("last", 32'(got.last), 32'(want.last));
		end
		word_no++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_table();
			expected_words.delete();
			word_no   = 0;
			err_count = 0;
			pending  <= 0;
		end else begin
			// Results go out first: a word leaving now belongs to an earlier request.
			if (m_tvalid && m_tready)
				check_word();
			if (cfg_we) begin
				if (cfg_addr == CFG_QUANTUM)
					quantum_reg = cfg_wdata;
				else
					overhead_reg = cfg_wdata;
			end
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata[15:0], s_tdata[19:16]);
			pending <= expected_words.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the scheduler testbench: clock, reset, request and register stimulus, verdict.
// Depends on rrqs_pkg, the round_robin_quantum_scheduler block and sched_checker.
module tb_top
	import rrqs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_200_000;
	localparam int          PHASES      = 6;
	localparam int          PHASE_ITEMS = 80;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic                  cfg_addr;
	logic [7:0]            cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;
	int unsigned           err_count;
	int unsigned           pending;
	int unsigned           cycles;
	int unsigned           stall_left;
	int unsigned           stall_len;
	bit                    no_idle;

	round_robin_quantum_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	sched_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.err_count (err_count),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Result side: after each accepted word, hold ready low for a random stretch, which may be empty.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (m_tready && m_tvalid) begin
			stall_len = no_idle ? 0 : $urandom_range(0, 11);
			if (stall_len == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready   <= 1'b0;
				stall_left <= stall_len - 1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Valid stays high into the next word when no gap is drawn.
	task automatic send_req(input logic [1:0] req, input logic [15:0] owner,
		input logic [3:0] idx);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {4'd0, idx, owner};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] quantum, input logic [7:0] overhead);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_QUANTUM;
		cfg_wdata <= quantum;
		@(posedge clk);
		cfg_addr  <= CFG_OVERHEAD;
		cfg_wdata <= overhead;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// A few owners recur so that removals hit real jobs; the rest spans all bits.
	function automatic logic [15:0] pick_owner();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h5A5A;
			3:       return 16'hA5A5;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_random();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_req(REQ_ADD, pick_owner(), 4'd0);
		else if (pick < 60)
			send_req(REQ_REMOVE, pick_owner(), 4'd0);
		else if (pick < 75)
			send_req(REQ_RUN, 16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
		else
			send_req(REQ_READ, 16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
	endtask

	initial begin
		logic [7:0] q_set [PHASES];
		logic [7:0] ov_set [PHASES];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = CFG_QUANTUM;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_ADD;
		cycles    = 0;
		no_idle   = 0;
		q_set  = '{8'd1, 8'd255, 8'd2, 8'd3, 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 4))};
		ov_set = '{8'd0, 8'd255, 8'd7, 8'd0, 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty run, empty read, two jobs, read, run, read, removal of one owner, read.
		send_req(REQ_RUN, 16'h0000, 4'd0);
		send_req(REQ_READ, 16'h0000, 4'd15);
		send_req(REQ_ADD, 16'h0000, 4'd0);
		send_req(REQ_ADD, 16'hFFFF, 4'd0);
		send_req(REQ_READ, 16'h0000, 4'd0);
		send_req(REQ_RUN, 16'h0000, 4'd0);
		send_req(REQ_READ, 16'h0000, 4'd1);
		send_req(REQ_REMOVE, 16'hFFFF, 4'd0);
		send_req(REQ_READ, 16'h0000, 4'd1);
		wait_drained();

		// A zero quantum acts as one; fill the table, overflow it, run it all.
		set_config(8'd0, 8'd255);
		for (int i = 1; i < MAX_ENTRIES; i++)
			send_req(REQ_ADD, 16'(i), 4'd0);
		send_req(REQ_ADD, 16'h8000, 4'd0);
		send_req(REQ_RUN, 16'h0000, 4'd0);
		send_req(REQ_READ, 16'h0000, 4'd15);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			set_config(q_set[p], ov_set[p]);
			no_idle = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_random();
				if (p == 3 && n == PHASE_ITEMS / 2)
					wait_drained();
			end
			wait_drained();
		end
		no_idle = 0;
		repeat (40) @(posedge clk);

		if (err_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
